// ===== hdl/pps_pkg.sv =====
// Shared types and constants of the preemptive priority scheduler.
package pps_pkg;

  localparam int PRIO_W  = 4;
  localparam int TIME_W  = 16;
  localparam int BURST_W = 8;
  localparam int SLOT_W  = 3;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef logic [PRIO_W-1:0]  prio_t;
  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [BURST_W-1:0] burst_t;
  typedef logic [SLOT_W-1:0]  slot_t;

  typedef struct packed {
    logic   mode;
    slot_t  slot;
    prio_t  task_priority;
    time_t  arrival;
    burst_t burst;
  } in_item_t;

  typedef struct packed {
    time_t now;
    logic  running_valid;
    slot_t running_slot;
    logic  completed;
    slot_t completed_slot;
    time_t turnaround;
    time_t waiting;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_step;
    logic retire;
    logic emit;
  } pps_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } pps_sts_t;

endpackage

// ===== hdl/preemptive_priority_scheduler_unit.sv =====
// Top level of the preemptive priority scheduler.
// Each transaction on the input channel either loads one task slot or advances
// one scheduler tick, and yields exactly one result transaction. A load goes
// from the input register straight to the commit step that writes the result
// register; a tick first runs the scan that reads the task memories one slot
// per cycle through a single read port, followed by the retire and commit
// steps. One item is in work at a time; the next item is accepted in the cycle
// after the previous result enters the output register, even if that result is
// still stalled, and a stalled earlier result holds the commit step. Loads to
// slots at or above TASK_SLOTS are ignored apart from their result.
module preemptive_priority_scheduler_unit #(
  parameter int TASK_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pps_pkg::out_item_t out_data
);
  import pps_pkg::*;

  pps_cmd_t cmd;
  pps_sts_t sts;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pps_datapath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/pps_ctrl.sv =====
// Sequencer of the scheduler: handshake, slot scan and result commit.
module pps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_stall,
  input  pps_pkg::pps_sts_t sts,
  output pps_pkg::pps_cmd_t cmd
);
  import pps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_RETIRE,
    S_EMIT
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= (in_mode == MODE_TICK) ? S_SCAN : S_EMIT;
          end
        end
        S_SCAN: begin
          if (sts.scan_last) begin
            state_r <= S_LAST;
          end
        end
        S_LAST:   state_r <= S_RETIRE;
        S_RETIRE: state_r <= S_EMIT;
        S_EMIT: begin
          if (sts.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.accept     = (state_r == S_IDLE) && in_valid;
    cmd.scan_start = cmd.accept && (in_mode == MODE_TICK);
    cmd.scan_step  = (state_r == S_SCAN);
    cmd.retire     = (state_r == S_RETIRE);
    cmd.emit       = (state_r == S_EMIT) && sts.out_free;
  end

endmodule

// ===== hdl/pps_datapath.sv =====
// Task memories, scan evaluation, retire and preempt logic and result register.
module pps_datapath #(
  parameter int TASK_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pps_pkg::in_item_t  in_data,
  input  pps_pkg::pps_cmd_t  cmd,
  output pps_pkg::pps_sts_t  sts,
  output logic               out_valid,
  input  logic               out_stall,
  output pps_pkg::out_item_t out_data
);
  import pps_pkg::*;

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  typedef logic [IDX_W-1:0] idx_t;

  prio_t  prio_mem  [TASK_SLOTS];
  time_t  arr_mem   [TASK_SLOTS];
  burst_t burst_mem [TASK_SLOTS];
  burst_t rem_mem   [TASK_SLOTS];
  logic   vld_r     [TASK_SLOTS];

  in_item_t  in_r;
  idx_t      ptr_r;
  logic      q_valid_r;
  prio_t     rd_prio_r;
  time_t     rd_arr_r;
  burst_t    rd_burst_r;
  burst_t    rd_rem_r;
  logic      rd_vld_r;
  idx_t      rd_idx_r;

  logic      best_valid_r;
  idx_t      best_slot_r;
  prio_t     best_prio_r;
  burst_t    best_rem_r;
  prio_t     c_prio_r;
  time_t     c_arr_r;
  burst_t    c_burst_r;
  burst_t    c_rem_r;

  logic      cur_valid_r;
  idx_t      cur_slot_r;
  time_t     tick_r;
  logic      done_r;
  time_t     tat_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic      rd_rem_nz;
  logic      elig;
  logic      take;
  logic      hit_cur;
  logic      ld_ok;
  idx_t      ld_idx;
  logic      keep_cv;
  logic      pick;
  logic      new_cv;
  idx_t      new_slot;
  burst_t    new_rem;
  time_t     burst_w;
  time_t     wt;
  logic      ld_we;
  logic      rem_we;
  idx_t      rem_idx;
  burst_t    rem_data;
  logic [31:0] slot_w;
  logic [31:0] new_slot_w;
  logic [31:0] cur_slot_w;
  out_item_t res;

  // scan evaluation
  always_comb begin
    rd_rem_nz = rd_vld_r && (rd_rem_r != '0);
    elig      = q_valid_r && (rd_arr_r <= tick_r) && rd_rem_nz;
    take      = elig && (!best_valid_r || (rd_prio_r > best_prio_r));
    hit_cur   = q_valid_r && (rd_idx_r == cur_slot_r);
  end

  // load slot decode
  always_comb begin
    slot_w = 32'(in_r.slot);
    ld_ok  = (slot_w < 32'(TASK_SLOTS));
    ld_idx = slot_w[IDX_W-1:0];
  end

  // retire, preempt and decrement
  always_comb begin
    keep_cv  = cur_valid_r && !done_r;
    pick     = best_valid_r && (!keep_cv || (best_prio_r > c_prio_r));
    new_cv   = keep_cv || pick;
    new_slot = pick ? best_slot_r : cur_slot_r;
    new_rem  = pick ? best_rem_r : c_rem_r;
    burst_w  = TIME_W'(c_burst_r);
    wt       = (tat_r > burst_w) ? (tat_r - burst_w) : '0;
    ld_we    = cmd.emit && (in_r.mode == MODE_LOAD) && ld_ok;
    rem_we   = ld_we || (cmd.emit && (in_r.mode == MODE_TICK) && new_cv);
    rem_idx  = (in_r.mode == MODE_TICK) ? new_slot : ld_idx;
    rem_data = (in_r.mode == MODE_TICK) ? (new_rem - BURST_W'(1)) : in_r.burst;
  end

  // result assembly
  always_comb begin
    new_slot_w = 32'(new_slot);
    cur_slot_w = 32'(cur_slot_r);
    res        = '0;
    res.now    = tick_r;
    if (in_r.mode == MODE_TICK) begin
      res.running_valid = new_cv;
      res.running_slot  = new_cv ? new_slot_w[SLOT_W-1:0] : '0;
      res.completed     = done_r;
      if (done_r) begin
        res.completed_slot = cur_slot_w[SLOT_W-1:0];
        res.turnaround     = tat_r;
        res.waiting        = wt;
      end
    end else begin
      res.running_valid = cur_valid_r;
      res.running_slot  = cur_valid_r ? cur_slot_w[SLOT_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_we) begin
      prio_mem[ld_idx]  <= in_r.task_priority;
      arr_mem[ld_idx]   <= in_r.arrival;
      burst_mem[ld_idx] <= in_r.burst;
    end
    if (rem_we) begin
      rem_mem[rem_idx] <= rem_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rd_prio_r  <= prio_mem[ptr_r];
      rd_arr_r   <= arr_mem[ptr_r];
      rd_burst_r <= burst_mem[ptr_r];
      rd_rem_r   <= rem_mem[ptr_r];
      rd_vld_r   <= vld_r[ptr_r];
      rd_idx_r   <= ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (ld_we) begin
      vld_r[ld_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r        <= '0;
      q_valid_r    <= 1'b0;
      best_valid_r <= 1'b0;
      cur_valid_r  <= 1'b0;
      cur_slot_r   <= '0;
      tick_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      q_valid_r <= cmd.scan_step;
      if (cmd.scan_start) begin
        ptr_r        <= '0;
        best_valid_r <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          ptr_r <= ptr_r + IDX_W'(1);
        end
        if (take) begin
          best_valid_r <= 1'b1;
        end
      end
      if (cmd.emit && (in_r.mode == MODE_TICK)) begin
        cur_valid_r <= new_cv;
        cur_slot_r  <= new_slot;
        if (tick_r != '1) begin
          tick_r <= tick_r + TIME_W'(1);
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_r <= in_data;
    end
    if (take) begin
      best_slot_r <= rd_idx_r;
      best_prio_r <= rd_prio_r;
      best_rem_r  <= rd_rem_r;
    end
    if (hit_cur) begin
      c_prio_r  <= rd_prio_r;
      c_arr_r   <= rd_arr_r;
      c_burst_r <= rd_burst_r;
      c_rem_r   <= rd_vld_r ? rd_rem_r : '0;
    end
    if (cmd.retire) begin
      done_r <= cur_valid_r && (c_rem_r == '0);
      tat_r  <= (tick_r > c_arr_r) ? (tick_r - c_arr_r) : '0;
    end
    if (cmd.emit) begin
      out_data_r <= res;
    end
  end

  assign sts.scan_last = (ptr_r == IDX_W'(TASK_SLOTS - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

// ===== bench/pps_sched_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the preemptive priority scheduler: predicts each result and compares it.
module pps_sched_checker #(
  parameter int TASK_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  pps_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  pps_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 outstanding
);
  import pps_pkg::*;

  prio_t     task_prio    [TASK_SLOTS];
  time_t     task_arrival [TASK_SLOTS];
  burst_t    task_burst   [TASK_SLOTS];
  burst_t    task_left    [TASK_SLOTS];
  time_t     tick_now;
  slot_t     run_slot;
  logic      run_valid;
  out_item_t due;
  out_item_t sched_reports_q [$];

  function automatic out_item_t advance_schedule(input in_item_t it);
    out_item_t r;
    logic      found;
    slot_t     pick;
    r = '0;
    r.now = tick_now;
    if (it.mode == MODE_LOAD) begin
      if (int'(it.slot) < TASK_SLOTS) begin
        task_prio[it.slot]    = it.task_priority;
        task_arrival[it.slot] = it.arrival;
        task_burst[it.slot]   = it.burst;
        task_left[it.slot]    = it.burst;
      end
    end else begin
      if (run_valid && task_left[run_slot] == '0) begin
        r.completed      = 1'b1;
        r.completed_slot = run_slot;
        r.turnaround     = (tick_now > task_arrival[run_slot]) ?
                           tick_now - task_arrival[run_slot] : '0;
        r.waiting        = (r.turnaround > time_t'(task_burst[run_slot])) ?
                           r.turnaround - time_t'(task_burst[run_slot]) : '0;
        run_valid        = 1'b0;
      end
      found = 1'b0;
      pick  = '0;
      for (int s = 0; s < TASK_SLOTS; s++) begin
        if (task_arrival[s] <= tick_now && task_left[s] != '0 &&
            (!found || task_prio[s] > task_prio[pick])) begin
          pick  = slot_t'(s);
          found = 1'b1;
        end
      end
      // preempt only on strictly higher priority
      if (found && (!run_valid || task_prio[pick] > task_prio[run_slot])) begin
        run_slot  = pick;
        run_valid = 1'b1;
      end
      if (run_valid && task_left[run_slot] != '0) begin
        task_left[run_slot] = task_left[run_slot] - burst_t'(1);
      end
      if (tick_now != '1) begin
        tick_now = tick_now + time_t'(1);
      end
    end
    r.running_valid = run_valid;
    r.running_slot  = run_valid ? run_slot : '0;
    return r;
  endfunction

  task automatic flag_fault(input string what, input logic [15:0] want,
                            input logic [15:0] got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("pps check: %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < TASK_SLOTS; s++) begin
        task_prio[s]    = '0;
        task_arrival[s] = '0;
        task_burst[s]   = '0;
        task_left[s]    = '0;
      end
      tick_now   = '0;
      run_slot   = '0;
      run_valid  = 1'b0;
      fail_count = 0;
      sched_reports_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (sched_reports_q.size() == 0) begin
          flag_fault("transaction with nothing pending, now", '0, out_data.now);
        end else begin
          due = sched_reports_q.pop_front();
          if (out_data.now !== due.now) begin
            flag_fault("now", due.now, out_data.now);
          end
          if (out_data.running_valid !== due.running_valid) begin
            flag_fault("running_valid", 16'(due.running_valid),
                       16'(out_data.running_valid));
          end
          if (out_data.running_slot !== due.running_slot) begin
            flag_fault("running_slot", 16'(due.running_slot),
                       16'(out_data.running_slot));
          end
          if (out_data.completed !== due.completed) begin
            flag_fault("completed", 16'(due.completed), 16'(out_data.completed));
          end
          if (out_data.completed_slot !== due.completed_slot) begin
            flag_fault("completed_slot", 16'(due.completed_slot),
                       16'(out_data.completed_slot));
          end
          if (out_data.turnaround !== due.turnaround) begin
            flag_fault("turnaround", due.turnaround, out_data.turnaround);
          end
          if (out_data.waiting !== due.waiting) begin
            flag_fault("waiting", due.waiting, out_data.waiting);
          end
        end
      end
      if (in_valid && !in_stall) begin
        sched_reports_q.push_back(advance_schedule(in_data));
      end
    end
    outstanding = sched_reports_q.size();
  end

endmodule

// ===== bench/preemptive_priority_scheduler_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the preemptive priority scheduler: stimulus, pacing and verdict.
module preemptive_priority_scheduler_unit_tb;
  import pps_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 330;
  localparam int TICK_SAT     = 65535;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_COMB, STALL_HEAVY} stall_style_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  in_item_t     in_data = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  out_item_t    out_data;
  logic         in_taken = 1'b0;
  logic         stall_on = 1'b1;
  stall_style_t stall_style = STALL_NONE;
  int           stall_span = 0;
  int           comb_phase = 0;
  int           idle_cycles = 0;
  int           fail_count;
  int           outstanding;
  int           ticks_sent = 0;
  int           issued = 0;
  int           burst_left = 0;
  bit           pace_on = 1'b1;

  always #5 clk = ~clk;

  preemptive_priority_scheduler_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  pps_sched_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
  end

  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_style <= stall_style_t'($urandom_range(0, 3));
      stall_span  <= $urandom_range(20, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    comb_phase <= (comb_phase + 1) % 7;
    if (!stall_on) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_style)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
        STALL_COMB:  out_stall <= (comb_phase < 4);
        default:     out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic time_t tick_offset(input int delta);
    int t;
    t = ((ticks_sent > TICK_SAT) ? TICK_SAT : ticks_sent) + delta;
    if (t < 0) t = 0;
    if (t > TICK_SAT) t = TICK_SAT;
    return time_t'(t);
  endfunction

  function automatic in_item_t load_item(input int slot, input int prio,
                                         input time_t arrival, input int burst);
    in_item_t it;
    it.mode          = MODE_LOAD;
    it.slot          = slot_t'(slot);
    it.task_priority = prio_t'(prio);
    it.arrival       = arrival;
    it.burst         = burst_t'(burst);
    return it;
  endfunction

  function automatic in_item_t tick_item();
    in_item_t it;
    it      = in_item_t'($urandom);
    it.mode = MODE_TICK;
    return it;
  endfunction

  function automatic in_item_t random_load();
    int    pick;
    time_t arrival;
    int    burst;
    pick = $urandom_range(0, 9);
    if (pick < 8) arrival = tick_offset($urandom_range(0, 8));
    else if (pick == 8) arrival = tick_offset(-int'($urandom_range(0, 60)));
    else arrival = time_t'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 7) burst = $urandom_range(1, 6);
    else if (pick == 7) burst = 0;
    else if (pick == 8) burst = $urandom_range(7, 40);
    else burst = $urandom_range(0, 255);
    return load_item($urandom_range(0, 7), $urandom_range(0, 15), arrival, burst);
  endfunction

  task automatic issue(input in_item_t it);
    if (burst_left == 0) begin
      if (pace_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 16);
    end
    burst_left--;
    in_data  <= it;
    in_valid <= 1'b1;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
    if (it.mode == MODE_TICK) ticks_sent++;
    issued++;
  endtask

  // hold the sender until every expected transaction has come back
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int mix;
    int loads;
    int run_len;
    int random_end;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    issue(tick_item());
    issue(load_item(0, 0, 16'd0, 0));
    issue(load_item(7, 15, 16'hffff, 255));
    issue(tick_item());
    issue(load_item(1, 5, 16'd0, 2));
    issue(tick_item());
    issue(load_item(2, 9, 16'd0, 3));
    issue(load_item(3, 9, 16'd0, 4));
    issue(tick_item());
    issue(load_item(4, 9, 16'd0, 1));
    issue(tick_item());
    issue(load_item(2, 9, tick_offset(2), 3));
    repeat (4) issue(tick_item());
    issue(load_item(3, 9, tick_offset(40), 0));
    repeat (2) issue(tick_item());
    issue(load_item(5, 0, 16'd0, 1));
    repeat (3) issue(tick_item());
    drain();

    random_end = issued + RANDOM_ITEMS;
    while (issued < random_end) begin
      mix = $urandom_range(0, 99);
      if (mix < 15) begin
        issue(in_item_t'($urandom));
      end else begin
        loads = $urandom_range(1, 4);
        repeat (loads) issue(random_load());
        run_len = $urandom_range(3, 16);
        repeat (run_len) begin
          if ($urandom_range(0, 15) == 0) issue(random_load());
          issue(tick_item());
        end
      end
    end
    drain();

    // run a stretch of ticks back to back with the receiver never stalling
    pace_on = 1'b0;
    stall_on <= 1'b0;
    issue(load_item(1, 3, tick_offset(0), 20));
    repeat (24) issue(tick_item());
    pace_on = 1'b1;
    stall_on <= 1'b1;
    issue(load_item(6, 15, 16'hffff, 3));
    issue(load_item(0, 15, 16'hfffe, 2));
    repeat (8) issue(tick_item());
    drain();
    repeat (40) @(negedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
